FILE: rtl/core/fqd_pkg.sv
// Shared types, byte codes and decode helpers for the form query decoder.
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

	// Raw byte codes the parser reacts to
	localparam logic [7:0] CH_PCT     = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_EQ      = 8'h3D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_HIGH    = 8'h80;
	localparam logic [7:0] HEX_MASK   = 8'hDF;
	localparam logic [7:0] HEX_TEN    = 8'd10;

	// Escape progress codes
	localparam logic [1:0] PEND_NONE  = 2'd0;
	localparam logic [1:0] PEND_PCT   = 2'd1;
	localparam logic [1:0] PEND_DIGIT = 2'd2;

	// Most results one input byte can cause
	localparam int BUN_SLOTS = 3;

	typedef struct packed {
		logic       eop;
		logic       part;
		logic       has;
		logic [7:0] data;
	} res_t;

	// All results of one input byte, slot 0 first
	typedef struct packed {
		logic [1:0]                 cnt;
		res_t [BUN_SLOTS-1:0]       item;
	} bundle_t;

	// Escape state plus the bundle being built
	typedef struct packed {
		logic [1:0] pend;
		logic [7:0] fd;
		bundle_t    bun;
	} work_t;

	function automatic logic [7:0] hex_value(input logic [7:0] b);
		logic [7:0] r;
		if (b >= CH_UPPER_A && b < CH_HIGH) begin
			r = (b & HEX_MASK) - CH_UPPER_A + HEX_TEN;
		end else begin
			r = b - CH_ZERO;
		end
		return r;
	endfunction

	function automatic logic [7:0] plain_byte(input logic [7:0] b);
		return (b == CH_PLUS) ? CH_SPACE : b;
	endfunction

	function automatic bundle_t add_item(input bundle_t bi, input logic [7:0] b,
		input logic has, input logic part, input logic eop);
		bundle_t r;
		r = bi;
		r.item[bi.cnt].data = has ? b : 8'h00;
		r.item[bi.cnt].has  = has;
		r.item[bi.cnt].part = part;
		r.item[bi.cnt].eop  = eop;
		r.cnt = bi.cnt + 2'd1;
		return r;
	endfunction

	function automatic work_t feed(input work_t w, input logic [7:0] b, input logic part);
		work_t      r;
		logic [7:0] hi;
		logic [7:0] lo;
		r  = w;
		hi = hex_value(w.fd);
		lo = hex_value(b);
		case (w.pend)
			PEND_NONE: begin
				if (b == CH_PCT) begin
					r.pend = PEND_PCT;
				end else begin
					r.bun = add_item(r.bun, plain_byte(b), 1'b1, part, 1'b0);
				end
			end
			PEND_PCT: begin
				r.fd   = b;
				r.pend = PEND_DIGIT;
			end
			default: begin
				r.bun  = add_item(r.bun, {hi[3:0], 4'h0} + lo, 1'b1, part, 1'b0);
				r.pend = PEND_NONE;
				r.fd   = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic work_t flush(input work_t w, input logic part);
		work_t r;
		r = w;
		if (w.pend != PEND_NONE) begin
			r.bun = add_item(r.bun, CH_PCT, 1'b1, part, 1'b0);
		end
		if (w.pend == PEND_DIGIT) begin
			r.bun = add_item(r.bun, plain_byte(w.fd), 1'b1, part, 1'b0);
		end
		r.pend = PEND_NONE;
		r.fd   = 8'h00;
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/fqd_front.sv
// Front end: accepts raw bytes, tracks pair and escape state, builds result bundles.
`timescale 1ns / 1ps
`default_nettype none

module fqd_front
	import fqd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_final,
	input  wire logic       q_full,
	output logic            in_ready,
	output logic            push,
	output bundle_t         push_bun
);

	typedef enum logic [1:0] {M_START, M_KEY, M_VALUE, M_DROP} mode_t;

	mode_t      mode_q;
	mode_t      mode_n;
	logic [1:0] pend_q;
	logic [7:0] fd_q;
	work_t      w;
	logic       accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		w.pend = pend_q;
		w.fd   = fd_q;
		w.bun  = '0;
		mode_n = mode_q;
		case (mode_q)
			M_START: begin
				if (in_byte == CH_EQ) begin
					mode_n = M_DROP;
				end else if (in_byte != CH_AMP) begin
					mode_n = M_KEY;
					w = feed(w, in_byte, 1'b0);
				end
			end
			M_KEY: begin
				if (in_byte == CH_AMP) begin
					w = flush(w, 1'b0);
					w.bun = add_item(w.bun, 8'h00, 1'b0, 1'b1, 1'b1);
					mode_n = M_START;
				end else if (in_byte == CH_EQ) begin
					w = flush(w, 1'b0);
					mode_n = M_VALUE;
				end else begin
					w = feed(w, in_byte, 1'b0);
				end
			end
			M_VALUE: begin
				if (in_byte == CH_AMP) begin
					w = flush(w, 1'b1);
					w.bun = add_item(w.bun, 8'h00, 1'b0, 1'b1, 1'b1);
					mode_n = M_START;
				end else begin
					w = feed(w, in_byte, 1'b1);
				end
			end
			M_DROP: begin
				if (in_byte == CH_AMP) begin
					mode_n = M_START;
				end
			end
			default: begin
				mode_n = M_START;
			end
		endcase
		// close any open field at the end of the string
		if (in_final) begin
			if (mode_n == M_KEY || mode_n == M_VALUE) begin
				w = flush(w, mode_n == M_VALUE);
				w.bun = add_item(w.bun, 8'h00, 1'b0, 1'b1, 1'b1);
			end
			mode_n = M_START;
			w.pend = PEND_NONE;
			w.fd   = 8'h00;
		end
	end

	assign push     = accept && (w.bun.cnt != 2'd0);
	assign push_bun = w.bun;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_START;
			pend_q <= PEND_NONE;
			fd_q   <= 8'h00;
		end else if (accept) begin
			mode_q <= mode_n;
			pend_q <= w.pend;
			fd_q   <= w.fd;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fqd_queue.sv
// Bundle queue between the front end and the output sequencer.
`timescale 1ns / 1ps
`default_nettype none

module fqd_queue
	import fqd_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire bundle_t push_bun,
	input  wire logic    pop,
	output bundle_t      head,
	output logic         full,
	output logic         empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bundle_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_bun;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/fqd_back.sv
// Back end: unpacks queued bundles into single result items behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module fqd_back
	import fqd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire bundle_t head,
	input  wire logic    empty,
	output logic         pop,
	input  wire logic    out_ready,
	output logic         out_valid,
	output res_t         out_res,
	output logic         out_last
);

	logic [1:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	logic       last_q;
	logic       load;
	logic       is_last;

	assign load    = !empty && (!valid_q || out_ready);
	assign is_last = (idx_q == head.cnt - 2'd1);
	assign pop     = load && is_last;

	always_ff @(posedge clk) begin
		if (load) begin
			res_q  <= head.item[idx_q];
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire

FILE: rtl/core/form_query_decoder_core.sv
// Top level of the streaming form query decoder.
// A result passes through the bundle queue and then the output register before it shows on m_*.
// Throughput: one input item per cycle while each item yields at most one result and m_tready is high;
// an item that yields two or three results holds the single output register for each result
// in turn, and the bundle queue (QUEUE_DEPTH items) absorbs the difference.
// Reset: arst_n clears parse state, queue pointers and output valid at once.
`timescale 1ns / 1ps
`default_nettype none

module form_query_decoder_core
	import fqd_pkg::*;
#(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// input items: raw query string bytes
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // final_byte
	// result items: decoded bytes and pair markers
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [2:0]      m_tuser,   // [0] has_byte, [1] part, [2] end_of_pair
	output logic            m_tlast    // run_last
);

	logic    q_full;
	logic    q_empty;
	logic    push;
	logic    pop;
	bundle_t push_bun;
	bundle_t head;
	res_t    out_res;

	// Front: classify each byte and build every result it causes in one bundle
	fqd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_byte  (s_tdata),
		.in_final (s_tlast),
		.q_full   (q_full),
		.in_ready (s_tready),
		.push     (push),
		.push_bun (push_bun)
	);

	// Queue: hold bundles so the front keeps taking bytes while the output stalls
	fqd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_bun (push_bun),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	// Back: advance through the head bundle one result item per cycle while m_tready is high
	fqd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.out_last  (m_tlast)
	);

	assign m_tdata = out_res.data;
	assign m_tuser = {out_res.eop, out_res.part, out_res.has};

endmodule

`default_nettype wire

FILE: rtl/core/fqd_checker.sv
// Port-level checks for the form query decoder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fqd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [7:0] s_tdata,
	input wire logic       s_tlast,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [2:0] m_tuser,
	input wire logic       m_tlast
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// bare marker carries a zero byte
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 8'h00)
		else $error("marker with nonzero byte");

	// end-of-pair is a bare value-side marker
	a_eop_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> !m_tuser[0] && m_tuser[1])
		else $error("malformed end-of-pair marker");

	// end-of-pair always closes the run of its input byte
	a_eop_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tlast)
		else $error("end-of-pair not last of run");

endmodule

bind form_query_decoder_core fqd_checker u_fqd_checker (.*);

`default_nettype wire
